/* src/lft_pkg.sv */
package lft_pkg;

    // Command codes of an input transaction.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // Operation classes that the front end hands to the back end.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Configuration register indexes.
    localparam int         CFG_IDX_W      = 3;
    localparam logic [2:0] REG_DURATION   = 3'd0;
    localparam logic [2:0] REG_FIRST      = 3'd1;
    localparam logic [2:0] REG_LAST       = 3'd2;
    localparam logic [2:0] REG_LOOP_LIMIT = 3'd3;
    localparam logic [2:0] REG_BACKWARD   = 3'd4;
    localparam int         CFG_DATA_W     = 32;

    // Reset values of the configuration registers.
    localparam logic [31:0] DURATION_RST   = 32'd1000000;
    localparam logic [15:0] LOOP_LIMIT_RST = 16'd1;

    // Datapath widths.
    localparam int ACCUM_W    = 33;
    localparam int MAG_W      = 16;
    localparam int DIVIDEND_W = ACCUM_W + MAG_W;
    localparam int DIVISOR_W  = 32;

    // Depth of the queue between front end and back end.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  command;
        logic [23:0] elapsed_us;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] frame;
        logic               frame_changed;
        logic               finished;
        logic               running;
    } t_out_item;

    // One classified transaction waiting in the queue.
    typedef struct packed {
        logic [1:0]  op;
        logic [23:0] elapsed_us;
    } t_q_entry;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_head;

    // Divider request and response.
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quot;
        logic                  rem_nz;
    } t_div_rsp;

endpackage

/* src/lft_front.sv */
module lft_front
    import lft_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    output t_q_head  o_head,
    input  logic     i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_q_entry           r_q_data [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;
    t_q_entry           n_entry;

    assign o_in_stall = (r_count == CNT_W'(QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_count != '0);

    // Classify the incoming command into an operation.
    always_comb begin
        n_entry.elapsed_us = i_in_item.elapsed_us;
        case (i_in_item.command)
            CMD_TICK:  n_entry.op = OP_TICK;
            CMD_START: n_entry.op = OP_START;
            CMD_STOP:  n_entry.op = OP_STOP;
            default:   n_entry.op = OP_NOP;
        endcase
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_data[r_wr_ptr] <= n_entry;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_q_data[r_rd_ptr];

endmodule

/* src/lft_div.sv */
module lft_div
    import lft_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_active;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quot;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_sub;
    logic                  q_bit;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        rem_sh  = {r_rem, r_quot[DIVIDEND_W-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        q_bit   = !rem_sub[DIVISOR_W];
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
            end else if (r_active) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_active) begin
            r_quot <= {r_quot[DIVIDEND_W-2:0], q_bit};
            r_rem  <= q_bit ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.quot   = r_quot;
    assign o_rsp.rem_nz = (r_rem != '0);

endmodule

/* src/lft_back.sv */
module lft_back
    import lft_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_q_head               i_head,
    output logic                  o_pop,
    output t_div_req              o_div_req,
    input  t_div_rsp              i_div_rsp,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_DSTART = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_FRAME  = 3'd4;
    localparam logic [2:0] S_END    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    localparam int FRAME_W = DIVIDEND_W + 2;

    // Configuration registers.
    logic [31:0]        r_duration;
    logic signed [15:0] r_first;
    logic signed [15:0] r_last;
    logic [15:0]        r_loop_limit;
    logic               r_backward;

    // Timeline state.
    logic [2:0]            r_state;
    logic                  r_running;
    logic [ACCUM_W-1:0]    r_accum;
    logic signed [15:0]    r_shown;
    logic [15:0]           r_loops;
    logic                  r_changed;
    logic                  r_fin;
    logic                  r_neg;
    logic [DIVIDEND_W-1:0] r_prod;

    // Output register.
    logic      r_out_valid;
    t_out_item r_out_item;

    logic                      out_free;
    logic [ACCUM_W:0]          accum_sum;
    logic [ACCUM_W-1:0]        accum_sat;
    logic signed [16:0]        span;
    logic [16:0]               span_neg;
    logic [MAG_W-1:0]          mag;
    logic signed [FRAME_W-1:0] off;
    logic signed [FRAME_W-1:0] frame_full;
    logic signed [15:0]        frame_sat;
    logic [15:0]               loops_inc;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == S_IDLE) && i_head.valid;

    // Saturating accumulation of elapsed time.
    always_comb begin
        accum_sum = {1'b0, r_accum} + (ACCUM_W + 1)'(i_head.entry.elapsed_us);
        accum_sat = accum_sum[ACCUM_W] ? '1 : accum_sum[ACCUM_W-1:0];
    end

    // Signed span and its magnitude.
    always_comb begin
        span     = {r_last[15], r_last} - {r_first[15], r_first};
        span_neg = -span;
        mag      = span[16] ? span_neg[MAG_W-1:0] : span[MAG_W-1:0];
    end

    // Frame offset from the quotient, rounding, and saturation.
    always_comb begin
        if (r_neg) begin
            off = -$signed({2'b00, i_div_rsp.quot});
        end else begin
            off = $signed({2'b00, i_div_rsp.quot})
                + $signed(FRAME_W'(r_backward && i_div_rsp.rem_nz));
        end
        frame_full = $signed({{(FRAME_W - 16){r_first[15]}}, r_first}) + off;
        if (frame_full > $signed(FRAME_W'(32767))) begin
            frame_sat = 16'sh7FFF;
        end else if (frame_full < -$signed(FRAME_W'(32768))) begin
            frame_sat = 16'sh8000;
        end else begin
            frame_sat = frame_full[15:0];
        end
    end

    assign loops_inc = r_loops + 16'd1;

    // Divider request.
    assign o_div_req.start    = (r_state == S_DSTART);
    assign o_div_req.dividend = r_prod;
    assign o_div_req.divisor  = r_duration;

    // Configuration writes; a zero duration is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration   <= DURATION_RST;
            r_first      <= '0;
            r_last       <= '0;
            r_loop_limit <= LOOP_LIMIT_RST;
            r_backward   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DURATION: begin
                    if (i_cfg_wdata != '0) begin
                        r_duration <= i_cfg_wdata;
                    end
                end
                REG_FIRST:      r_first      <= i_cfg_wdata[15:0];
                REG_LAST:       r_last       <= i_cfg_wdata[15:0];
                REG_LOOP_LIMIT: r_loop_limit <= i_cfg_wdata[15:0];
                REG_BACKWARD:   r_backward   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Product of span magnitude and accumulated time.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod <= DIVIDEND_W'(mag) * DIVIDEND_W'(r_accum);
            r_neg  <= span[16];
        end
    end

    // Sequencer carrying out one transaction at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_running <= 1'b0;
            r_accum   <= '0;
            r_shown   <= '0;
            r_loops   <= '0;
            r_changed <= 1'b0;
            r_fin     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_changed <= 1'b0;
                        r_fin     <= 1'b0;
                        r_state   <= S_OUT;
                        case (i_head.entry.op)
                            OP_START: begin
                                r_accum   <= '0;
                                r_shown   <= r_first;
                                r_loops   <= '0;
                                r_running <= 1'b1;
                            end
                            OP_STOP: begin
                                r_running <= 1'b0;
                            end
                            OP_TICK: begin
                                if (r_running) begin
                                    r_accum <= accum_sat;
                                    r_state <= S_MUL;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_div_rsp.done) begin
                        r_state <= S_FRAME;
                    end
                end
                S_FRAME: begin
                    if (frame_sat != r_shown) begin
                        r_changed <= 1'b1;
                        r_shown   <= frame_sat;
                    end
                    r_state <= S_END;
                end
                S_END: begin
                    // Check for the end of a pass: count it, then finish or restart.
                    if (r_accum >= ACCUM_W'(r_duration)) begin
                        r_loops <= loops_inc;
                        if (r_loop_limit != '0 && r_loop_limit == loops_inc) begin
                            r_fin     <= 1'b1;
                            r_running <= 1'b0;
                        end else begin
                            r_accum <= '0;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output valid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_item.frame         <= r_shown;
            r_out_item.frame_changed <= r_changed;
            r_out_item.finished      <= r_fin;
            r_out_item.running       <= r_running;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* src/looping_frame_timeline_unit.sv */
// Channel   Direction  Handshake               Payload
// input     in         i_in_valid / o_in_stall  i_in_item  (t_in_item)
// output    out        o_out_valid / i_out_stall o_out_item (t_out_item)
// config    in         i_cfg_we                 i_cfg_idx, i_cfg_wdata
//
// A tick while running steps the back end through multiply, divider start, the
// bit-serial divider (one quotient bit per cycle over 49 bits), frame and end.
// Start, stop, idle ticks and unused commands go straight to the output state.
// Reset is synchronous and active low; it restores register defaults and idles.
// A two-entry queue takes new transactions while the back end works or the
// output register waits on i_out_stall.
module looping_frame_timeline_unit
    import lft_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_q_head  head;
    logic     pop;
    t_div_req div_req;
    t_div_rsp div_rsp;

    // Front end: accepts and classifies transactions into the queue.
    lft_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_head     (head),
        .i_pop      (pop)
    );

    // Serial divider used by the back end.
    lft_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Back end: timeline state, frame computation and output register.
    lft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_head      (head),
        .o_pop       (pop),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
